/* rtl/bdpc_pkg.sv */
`default_nettype none

package bdpc_pkg;

  localparam int CFG_WIDTH           = 16;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd200;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd1;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] long_press_ticks;
  } bdpc_cfg_t;

  typedef struct packed {
    logic short_click;
    logic long_press;
    logic stable_level;
  } bdpc_result_t;

endpackage

`default_nettype wire

/* rtl/bdpc_cfg_regs.sv */
`default_nettype none

module bdpc_cfg_regs
  import bdpc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  wire logic [CFG_WIDTH-1:0]       wr_data,
  output bdpc_cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE:   cfg.debounce_ticks   <= wr_data;
        REG_LONG_PRESS: cfg.long_press_ticks <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/bdpc_core.sv */
`default_nettype none

module bdpc_core
  import bdpc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire logic  raw,
  input  wire bdpc_cfg_t cfg,
  output bdpc_result_t result
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  logic                   previous_raw, previous_raw_next;
  logic [COUNT_WIDTH-1:0] unchanged_count, unchanged_count_next;
  logic                   debounced_level, debounced_level_next;
  logic [COUNT_WIDTH-1:0] press_count, press_count_next;
  logic                   press_active, press_active_next;
  logic                   long_handled, long_handled_next;
  logic                   level_change;

  always_comb begin
    press_count_next     = press_count;
    press_active_next    = press_active;
    long_handled_next    = long_handled;
    debounced_level_next = debounced_level;
    previous_raw_next    = raw;
    result               = '0;

    if (press_active && (press_count != '1)) begin
      press_count_next = press_count + 1'b1;
    end

    if (raw != previous_raw) begin
      unchanged_count_next = '0;
    end else if (unchanged_count != '1) begin
      unchanged_count_next = unchanged_count + 1'b1;
    end else begin
      unchanged_count_next = unchanged_count;
    end

    level_change = (CMP_W'(unchanged_count_next) > CMP_W'(cfg.debounce_ticks)) &&
                   (raw != debounced_level);

    if (level_change) begin
      debounced_level_next = raw;
      if (!raw) begin
        press_count_next  = '0;
        press_active_next = 1'b1;
        long_handled_next = 1'b0;
      end else begin
        result.short_click = press_active && !long_handled;
        press_active_next  = 1'b0;
      end
    end

    if (!debounced_level_next && press_active_next && !long_handled_next &&
        (CMP_W'(press_count_next) > CMP_W'(cfg.long_press_ticks))) begin
      long_handled_next = 1'b1;
      result.long_press = 1'b1;
    end

    result.stable_level = debounced_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw    <= 1'b1;
      unchanged_count <= '1;
      debounced_level <= 1'b1;
      press_count     <= '0;
      press_active    <= 1'b0;
      long_handled    <= 1'b0;
    end else if (step) begin
      previous_raw    <= previous_raw_next;
      unchanged_count <= unchanged_count_next;
      debounced_level <= debounced_level_next;
      press_count     <= press_count_next;
      press_active    <= press_active_next;
      long_handled    <= long_handled_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/button_debounce_press_classifier_unit.sv */
// an accepted input beat is registered in stage 1, and its result beat in the output registers
// throughput: one beat per cycle while the result beat is not stalled, set by the state update in the core
// the input stalls only while both registers hold a beat and the result beat is stalled
// reset (rst, synchronous, active high): both stages empty, button state released,
// debounce counter saturated, registers back to 50 and 200 ticks
`default_nettype none

module button_debounce_press_classifier_unit
  import bdpc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       raw_level,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            short_click,
  output logic                            long_press,
  output logic                            stable_level,
  input  wire logic                       wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  wire logic [CFG_WIDTH-1:0]       wr_data
);

  bdpc_cfg_t    cfg;
  bdpc_result_t result;

  logic s1_valid, s1_valid_next;
  logic s1_raw;
  logic out_valid_next;
  logic advance;
  logic in_take;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw <= raw_level;
    end
    if (advance) begin
      short_click  <= result.short_click;
      long_press   <= result.long_press;
      stable_level <= result.stable_level;
    end
  end

  bdpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  bdpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .raw    (s1_raw),
    .cfg    (cfg),
    .result (result)
  );

endmodule

`default_nettype wire

/* rtl/bdpc_checker.sv */
`default_nettype none

module bdpc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic short_click,
  input wire logic long_press,
  input wire logic stable_level
);

  // pulses are exclusive
  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(short_click && long_press))
    else $error("short and long pulse in one beat");

  // long press only while held
  a_long_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_press) |-> !stable_level)
    else $error("long press with released level");

  // short click only on release
  a_short_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && short_click) |-> stable_level)
    else $error("short click with pressed level");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(short_click) &&
                                  $stable(long_press) && $stable(stable_level)))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .short_click  (short_click),
  .long_press   (long_press),
  .stable_level (stable_level)
);

`default_nettype wire
